// ----- rtl/ett_pkg.sv -----
// Shared types and constants for the eased tween table.
// Used by ett_ctrl, ett_dp and eased_tween_table.
`timescale 1ns / 1ps
`default_nettype none
package ett_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAX_SLOTS = 64;
	localparam int FRAC_MAX = 24;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [1:0] EASE_LINEAR = 2'd0;
	localparam logic [1:0] EASE_QUAD_IN = 2'd1;
	localparam logic [1:0] EASE_QUAD_OUT = 2'd2;
	localparam logic [1:0] EASE_QUAD_IO = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  slot_index;
		logic signed [31:0] start_value;
		logic signed [31:0] end_value;
		logic [31:0] duration_us;
		logic [1:0]  easing_mode;
		logic [31:0] delta_us;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  slot_id;
		logic signed [31:0] current_value;
		logic        finished;
		logic        last_result;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_EASE,
		ST_MUL,
		ST_SUM,
		ST_EMIT
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_start;
		logic latch_tick;
		logic clr_scan;
		logic next_slot;
		logic read_slot;
		logic do_check;
		logic div_start;
		logic do_ease;
		logic do_mul;
		logic do_sum;
		logic out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_running;
		logic scan_done;
		logic is_done;
		logic div_busy;
		logic out_full;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/ett_ctrl.sv -----
// Controller state machine for the eased tween table.
// Depends on ett_pkg; drives ett_dp through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module ett_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_is_tick,
	output logic                    in_stall,
	input  wire ett_pkg::dp_stat_t  stat,
	output ett_pkg::dp_cmd_t        cmd
);
	ett_pkg::ctrl_state_t state_q, state_nx;
	logic in_take;

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ett_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ett_pkg::ST_IDLE: begin
				if (in_take && in_is_tick) state_nx = ett_pkg::ST_SCAN;
			end
			ett_pkg::ST_SCAN: begin
				if (stat.scan_done) state_nx = ett_pkg::ST_IDLE;
				else if (stat.slot_running) state_nx = ett_pkg::ST_READ;
			end
			ett_pkg::ST_READ:  state_nx = ett_pkg::ST_CHECK;
			ett_pkg::ST_CHECK: begin
				state_nx = stat.is_done ? ett_pkg::ST_EMIT : ett_pkg::ST_DIV;
			end
			ett_pkg::ST_DIV: begin
				if (!stat.div_busy) state_nx = ett_pkg::ST_EASE;
			end
			ett_pkg::ST_EASE: state_nx = ett_pkg::ST_MUL;
			ett_pkg::ST_MUL:  state_nx = ett_pkg::ST_SUM;
			ett_pkg::ST_SUM:  state_nx = ett_pkg::ST_EMIT;
			ett_pkg::ST_EMIT: begin
				if (!stat.out_full) state_nx = ett_pkg::ST_SCAN;
			end
			default: state_nx = ett_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ett_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_start = !in_is_tick;
					cmd.latch_tick = in_is_tick;
					cmd.clr_scan   = in_is_tick;
				end
			end
			ett_pkg::ST_SCAN: begin
				if (!stat.scan_done && !stat.slot_running) cmd.next_slot = 1'b1;
			end
			ett_pkg::ST_READ:  cmd.read_slot = 1'b1;
			ett_pkg::ST_CHECK: begin
				cmd.do_check = 1'b1;
				cmd.div_start = !stat.is_done;
			end
			ett_pkg::ST_EASE: cmd.do_ease = 1'b1;
			ett_pkg::ST_MUL:  cmd.do_mul = 1'b1;
			ett_pkg::ST_SUM:  cmd.do_sum = 1'b1;
			ett_pkg::ST_EMIT: begin
				if (!stat.out_full) begin
					cmd.out_load = 1'b1;
					cmd.next_slot = 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ett_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_emit_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ett_pkg::ST_SCAN))
		else $error("emit did not return to scan");
	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && in_is_tick) |=> (state_q == ett_pkg::ST_SCAN))
		else $error("tick did not start scan");
endmodule
`default_nettype wire

// ----- rtl/ett_dp.sv -----
// Datapath for the eased tween table: slot stores, serial divider,
// easing multiply, value multiply and output register. Depends on ett_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ett_dp #(
	parameter int SLOTS = ett_pkg::SLOTS_DEF,
	parameter int FRAC_BITS = ett_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ett_pkg::in_beat_t  in_data,
	input  wire ett_pkg::dp_cmd_t   cmd,
	output ett_pkg::dp_stat_t       stat,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output ett_pkg::out_beat_t      out_data
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int TW = FRAC_BITS + 1;          // t and e fit [0, ONE]
	localparam int NW = 32 + FRAC_BITS;         // dividend width
	localparam int DCW = $clog2(NW + 1);
	localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;
	localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);

	// slot stores
	logic [31:0] elapsed_q [SLOTS];
	logic [31:0] begin_q   [SLOTS];
	logic [31:0] target_q  [SLOTS];
	logic [31:0] length_q  [SLOTS];
	logic [1:0]  curve_q   [SLOTS];
	logic [SLOTS-1:0] run_q;

	logic [31:0] delta_q;
	logic [CW-1:0] scan_q;
	logic [SW-1:0] slot;
	logic [31:0] sum_q, len_q, beg_q, tgt_q;
	logic [1:0]  crv_q;
	logic        done_q;
	logic [31:0] sum_sat;
	logic [32:0] sum_w;

	// serial restoring divider
	logic [NW-1:0] quo_q;
	logic [31:0]   rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [32:0]   rem_sh, rem_sub;

	logic [TW-1:0] e_q, t_w, u_w;
	logic [2*TW-1:0] sq_w;
	logic [TW-1:0] sqin_w;
	logic signed [33:0] diff_w;
	logic signed [33+TW:0] prod_q;
	logic signed [33:0] val_w;

	assign slot = scan_q[SW-1:0];
	assign stat.scan_done = (scan_q == CW'(SLOTS));
	assign stat.slot_running = !stat.scan_done && run_q[slot];
	assign sum_w = {1'b0, elapsed_q[slot]} + {1'b0, delta_q};
	assign sum_sat = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
	assign stat.is_done = (sum_q >= len_q);
	assign stat.div_busy = (dcnt_q != '0);
	assign stat.out_full = out_valid && out_stall;

	// per-slot stores and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			for (int i = 0; i < SLOTS; i++) elapsed_q[i] <= '0;
		end else begin
			if (cmd.load_start && (32'(in_data.slot_index) < 32'(SLOTS))) begin
				elapsed_q[in_data.slot_index[SW-1:0]] <= '0;
				run_q[in_data.slot_index[SW-1:0]] <= 1'b1;
			end
			if (cmd.read_slot) elapsed_q[slot] <= sum_sat;
			if (cmd.do_check && stat.is_done) run_q[slot] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start && (32'(in_data.slot_index) < 32'(SLOTS))) begin
			begin_q[in_data.slot_index[SW-1:0]]  <= in_data.start_value;
			target_q[in_data.slot_index[SW-1:0]] <= in_data.end_value;
			length_q[in_data.slot_index[SW-1:0]] <= in_data.duration_us;
			curve_q[in_data.slot_index[SW-1:0]]  <= in_data.easing_mode;
		end
		if (cmd.latch_tick) delta_q <= in_data.delta_us;
		if (cmd.read_slot) begin
			sum_q <= sum_sat;
			len_q <= length_q[slot];
			beg_q <= begin_q[slot];
			tgt_q <= target_q[slot];
			crv_q <= curve_q[slot];
		end
		if (cmd.do_check) done_q <= stat.is_done;
	end

	// scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.clr_scan) begin
			scan_q <= '0;
		end else if (cmd.next_slot) begin
			scan_q <= scan_q + CW'(1);
		end
	end

	// one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, len_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= DCW'(NW);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - DCW'(1);
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= {sum_q, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
		end else if (dcnt_q != '0) begin
			// remainder stays below the divisor, so bit 32 is dropped safely
			if (!rem_sub[32]) begin
				rem_q <= rem_sub[31:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// easing: t < ONE since sum < length
	assign t_w = quo_q[TW-1:0];
	assign u_w = ONE - t_w;
	always_comb begin
		sqin_w = '0;
		case (crv_q)
			ett_pkg::EASE_QUAD_IN:  sqin_w = t_w;
			ett_pkg::EASE_QUAD_OUT: sqin_w = u_w;
			ett_pkg::EASE_QUAD_IO:  sqin_w = (t_w < HALF) ? t_w : u_w;
			default:                sqin_w = t_w;
		endcase
	end
	assign sq_w = sqin_w * sqin_w;

	always_ff @(posedge clk) begin
		if (cmd.do_ease) begin
			case (crv_q)
				ett_pkg::EASE_LINEAR:   e_q <= t_w;
				ett_pkg::EASE_QUAD_IN:  e_q <= TW'(sq_w >> FRAC_BITS);
				ett_pkg::EASE_QUAD_OUT: e_q <= ONE - TW'(sq_w >> FRAC_BITS);
				ett_pkg::EASE_QUAD_IO: begin
					if (t_w < HALF) e_q <= TW'(sq_w >> (FRAC_BITS - 1));
					else e_q <= ONE - TW'(sq_w >> (FRAC_BITS - 1));
				end
				default: e_q <= t_w;
			endcase
		end
	end

	// value multiply, then floor shift and add
	assign diff_w = 34'(signed'(tgt_q)) - 34'(signed'(beg_q));
	always_ff @(posedge clk) begin
		if (cmd.do_mul) prod_q <= (34+TW)'(diff_w) * signed'({1'b0, e_q});
	end
	assign val_w = 34'(signed'(beg_q)) + 34'(prod_q >>> FRAC_BITS);

	logic [31:0] res_q;
	always_ff @(posedge clk) begin
		if (cmd.do_sum) res_q <= val_w[31:0];
	end

	// output register
	logic more_after;
	always_comb begin
		more_after = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (i > 32'(slot) && run_q[i]) more_after = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data.slot_id       <= 3'(slot);
			out_data.current_value <= done_q ? tgt_q : res_q;
			out_data.finished      <= done_q;
			out_data.last_result   <= !more_after;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.out_load)
		else $error("output overwritten while stalled");
	a_div_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (dcnt_q == '0))
		else $error("divider restarted while busy");
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_check && stat.is_done) |=> !run_q[$past(slot)])
		else $error("finished slot still running");
endmodule
`default_nettype wire

// ----- rtl/eased_tween_table.sv -----
// Channel | dir | handshake         | beat
// in      | in  | in_valid/in_stall | ett_pkg::in_beat_t
// out     | out | out_valid/out_stall | ett_pkg::out_beat_t
// A start beat is taken in the idle state and starts no walk. A tick walks
// the slots in order; a running slot passes through read, check, the serial
// divider, ease, multiply, sum and emit. A slot that finishes on the tick
// goes from check straight to emit; an idle slot is skipped by the scan.
// Reset clears all running flags and elapsed times at once.
// An output stall holds the result register and pauses the walk.
`timescale 1ns / 1ps
`default_nettype none
module eased_tween_table #(
	parameter int SLOTS = ett_pkg::SLOTS_DEF,
	parameter int FRAC_BITS = ett_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire ett_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output ett_pkg::out_beat_t      out_data
);
	ett_pkg::dp_cmd_t  cmd;
	ett_pkg::dp_stat_t stat;

	ett_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_is_tick(in_data.req_type == ett_pkg::REQ_TICK),
		.in_stall(in_stall), .stat(stat), .cmd(cmd)
	);

	ett_dp #(.SLOTS(SLOTS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule
`default_nettype wire

// ----- tb/tween_checker.sv -----
// Checker for the eased tween table: watches both channels, predicts results.
// Depends on ett_pkg for the beat types, request and easing codes.
`timescale 1ns / 1ps
module tween_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  ett_pkg::in_beat_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  ett_pkg::out_beat_t out_data,
	output int                 fail_count,
	output int                 pending
);
	localparam int NSLOT = 8;
	localparam int FB = 16;
	localparam logic [63:0] ONE = 64'd1 << FB;

	logic [31:0] elapsed_q [NSLOT];
	logic [31:0] begin_q [NSLOT];
	logic [31:0] target_q [NSLOT];
	logic [31:0] length_q [NSLOT];
	logic [1:0]  curve_q [NSLOT];
	logic        running_q [NSLOT];

	ett_pkg::out_beat_t value_queue [$];

	assign pending = value_queue.size();

	// eased fraction for a Q0.16 time t
	function automatic logic [63:0] eased_fraction(logic [63:0] t, logic [1:0] mode);
		logic [63:0] u;
		u = ONE - t;
		case (mode)
			ett_pkg::EASE_LINEAR: return t;
			ett_pkg::EASE_QUAD_IN: return (t * t) >> FB;
			ett_pkg::EASE_QUAD_OUT: return ONE - ((u * u) >> FB);
			default: begin
				if (t < (ONE >> 1))
					return (2 * t * t) >> FB;
				return ONE - ((2 * u * u) >> FB);
			end
		endcase
	endfunction

	// interpolated value, floor shift on the signed product
	function automatic logic [31:0] tween_value(logic [31:0] a, logic [31:0] b,
			logic [63:0] w);
		longint sa, sb, p;
		sa = longint'($signed(a));
		sb = longint'($signed(b));
		p = (sb - sa) * longint'(w);
		return 32'(sa + (p >>> FB));
	endfunction

	// apply one accepted input beat to the predicted table
	task automatic predict_beat(ett_pkg::in_beat_t b);
		logic [31:0] sum;
		logic [63:0] t;
		ett_pkg::out_beat_t r;
		int last_idx;
		if (b.req_type == ett_pkg::REQ_START) begin
			begin_q[b.slot_index] = b.start_value;
			target_q[b.slot_index] = b.end_value;
			length_q[b.slot_index] = b.duration_us;
			curve_q[b.slot_index] = b.easing_mode;
			elapsed_q[b.slot_index] = '0;
			running_q[b.slot_index] = 1'b1;
		end else begin
			last_idx = -1;
			for (int i = 0; i < NSLOT; i++) begin
				if (running_q[i]) begin
					sum = elapsed_q[i] + b.delta_us;
					if (sum < elapsed_q[i])
						sum = 32'hFFFF_FFFF;
					elapsed_q[i] = sum;
					r.slot_id = 3'(i);
					r.last_result = 1'b0;
					if (sum >= length_q[i]) begin
						r.current_value = target_q[i];
						r.finished = 1'b1;
						running_q[i] = 1'b0;
					end else begin
						t = ({32'd0, sum} << FB) / {32'd0, length_q[i]};
						r.current_value = tween_value(begin_q[i], target_q[i],
							eased_fraction(t, curve_q[i]));
						r.finished = 1'b0;
					end
					value_queue.push_back(r);
					last_idx = value_queue.size() - 1;
				end
			end
			if (last_idx >= 0)
				value_queue[last_idx].last_result = 1'b1;
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		ett_pkg::out_beat_t exp_beat;
		if (!arst_n) begin
			fail_count <= 0;
			for (int i = 0; i < NSLOT; i++) begin
				elapsed_q[i] = '0;
				running_q[i] = 1'b0;
			end
			value_queue.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (value_queue.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_beat = value_queue.pop_front();
					if (exp_beat !== out_data) begin
						$display("%0t: result mismatch expected %p actual %p",
							$time, exp_beat, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_beat(in_data);
		end
	end
endmodule

// ----- tb/tb.sv -----
// Top of the eased tween table testbench: clock, reset, stimulus, verdict.
// Depends on ett_pkg, eased_tween_table and tween_checker.
`timescale 1ns / 1ps
module tb;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ett_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ett_pkg::out_beat_t out_data;
	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles = 0;
	logic run_done = 1'b0;

	eased_tween_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	tween_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver stalls at random
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !run_done) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// drive one beat and hold it until accepted; valid drops on the next idle
	task automatic send_beat(ett_pkg::in_beat_t b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and wait until every expected result has come
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic start_slot(logic [2:0] s, logic [31:0] a, logic [31:0] b,
			logic [31:0] d, logic [1:0] m);
		ett_pkg::in_beat_t x;
		x = '0;
		x.req_type = ett_pkg::REQ_START;
		x.slot_index = s;
		x.start_value = a;
		x.end_value = b;
		x.duration_us = d;
		x.easing_mode = m;
		x.delta_us = $urandom;
		send_beat(x);
	endtask

	task automatic tick(logic [31:0] dt);
		ett_pkg::in_beat_t x;
		x = ett_pkg::in_beat_t'($bits(ett_pkg::in_beat_t)'(
			{$urandom, $urandom, $urandom, $urandom, $urandom}));
		x.req_type = ett_pkg::REQ_TICK;
		x.delta_us = dt;
		send_beat(x);
	endtask

	function automatic logic [31:0] rand_duration();
		case ($urandom_range(3))
			0: return $urandom_range(16);
			1: return $urandom_range(2000);
			2: return $urandom;
			default: return 32'hFFFF_FFFF - $urandom_range(3);
		endcase
	endfunction

	function automatic logic [31:0] rand_delta(logic [31:0] d);
		case ($urandom_range(4))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'hFFFF_FFFF;
			default: return (d >> $urandom_range(4)) + $urandom_range(3);
		endcase
	endfunction

	initial begin
		logic [31:0] dur;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty tick, extremes, every curve, zero duration, restart
		tick(32'd5);
		start_slot(3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1000, ett_pkg::EASE_LINEAR);
		start_slot(3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1000, ett_pkg::EASE_QUAD_IN);
		start_slot(3'd2, 32'h0001_0000, 32'hFFFF_0000, 32'd1000, ett_pkg::EASE_QUAD_OUT);
		start_slot(3'd3, 32'hFFFF_FFFF, 32'h0000_0000, 32'd1000, ett_pkg::EASE_QUAD_IO);
		start_slot(3'd4, 32'h1234_5678, 32'h0000_1111, 32'd0, ett_pkg::EASE_LINEAR);
		start_slot(3'd7, 32'h0, 32'h0010_0000, 32'hFFFF_FFFF, ett_pkg::EASE_QUAD_IO);
		tick(32'd0);
		tick(32'd250);
		tick(32'd250);
		start_slot(3'd0, 32'h0, 32'h0100_0000, 32'd3, ett_pkg::EASE_QUAD_IO);
		tick(32'd1);
		tick(32'd1);
		tick(32'hFFFF_FFFF);
		tick(32'hFFFF_FFFF);
		tick(32'd7);

		// random phases with different idling
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 63 : 0;
			recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 6 : 0;
			for (int n = 0; n < 130; n++) begin
				dur = rand_duration();
				if ($urandom_range(99) < 45)
					start_slot(3'($urandom), $urandom, $urandom, dur, 2'($urandom));
				else
					tick(rand_delta(dur));
				// hold off until the table has drained
				if (n == 60)
					drain();
			end
		end

		drain();
		repeat (500) @(negedge clk);
		run_done = 1'b1;
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- eased_tween_table.f -----
rtl/ett_pkg.sv
rtl/ett_ctrl.sv
rtl/ett_dp.sv
rtl/eased_tween_table.sv
tb/tween_checker.sv
tb/tb.sv
